// File: rtl/mrt_pkg.sv
package mrt_pkg;

  // Operation codes carried in s_axis_tuser
  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_QUERY = 2'd2
  } mrt_op_e;

  // Address window for mapped regions: [WinLow, WinHigh)
  localparam logic [31:0] WinLow  = 32'h6000_0000;
  localparam logic [31:0] WinHigh = 32'h8000_0000;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned OpW      = 2;

  // One stored region
  typedef struct packed {
    logic [31:0] start;
    logic [30:0] len;
    logic [4:0]  file;
  } mrt_entry_t;

endpackage

// File: rtl/mrt_slot_mem.sv
module mrt_slot_mem
  import mrt_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  mrt_entry_t    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output mrt_entry_t    rdata_o
);

  mrt_entry_t mem_q [DEPTH];

  // Write one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/mapped_region_table.sv
// Map and unmap scan every slot (ST_SCAN, then ST_LAST), a query reads its one slot in
// ST_QREAD, and an unknown operation goes straight to ST_COMMIT, where every result is
// registered; it then waits in ST_RESP until taken. One item at a time: no new item is
// taken until the result is taken. The slot scan reads one slot per cycle from the single
// read port of the slot memory.
// Reset clears the valid bits, the region count and the sequencer; slot contents are
// left as they are and are only shown for live slots.
module mapped_region_table
  import mrt_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 16,
  parameter int unsigned PAGE_BYTES  = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input item
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [31:0] addr, [63:32] length, [64] flag_fixed, [65] flag_shared,
  // [66] flag_anonymous, [70:67] file_slot, [74:71] entry_index, [79:75] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [1:0] operation
  input  logic [OpW-1:0]      s_axis_tuser,
  // Result item
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] status, [32:1] result_addr, [63:33] result_length, [68:64] result_file,
  // [69] slot_live, [74:70] region_count, [79:75] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);
  localparam logic [31:0] PageMask = 32'(PAGE_BYTES - 1);
  localparam logic [IW-1:0] LastIdx = IW'(TABLE_SLOTS - 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_LAST   = 6'b000100,
    ST_QREAD  = 6'b001000,
    ST_COMMIT = 6'b010000,
    ST_RESP   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Latched request
  logic [OpW-1:0] req_op_q;
  logic [31:0]    req_addr_q;
  logic [31:0]    req_len_q;
  logic [32:0]    req_end_q;
  logic           req_fixed_q, req_shared_q, req_anon_q;
  logic [3:0]     req_fd_q, req_idx_q;

  // Scan counter and compare stage
  logic [IW-1:0]  cnt_q, cnt_d;
  logic [IW-1:0]  rd_addr;
  logic           cmp_vld_q;
  logic [IW-1:0]  cmp_idx_q;
  mrt_entry_t     rd_data;

  // Scan results
  logic           hit_q, free_found_q, match_found_q;
  logic [IW-1:0]  free_idx_q, match_idx_q;

  logic [TABLE_SLOTS-1:0] valid_q;
  logic [CW-1:0]  live_cnt_q;

  logic [OutDataW-1:0] out_q, out_d;

  logic           in_acc;
  logic           slot_live_w, overlap_w, match_w;
  logic [32:0]    slot_end_w;
  logic           pre_ok, map_ok, unmap_ok, idx_ok;
  logic           mem_we;
  mrt_entry_t     wr_entry;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = state_q == ST_RESP;
  assign m_axis_tdata  = out_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rd_addr = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_acc) begin
          case (s_axis_tuser)
            OP_MAP, OP_UNMAP: state_d = ST_SCAN;
            OP_QUERY:         state_d = ST_QREAD;
            default:          state_d = ST_COMMIT;
          endcase
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST:  state_d = ST_COMMIT;
      ST_QREAD: begin
        rd_addr = IW'(req_idx_q);
        state_d = ST_COMMIT;
      end
      ST_COMMIT: state_d = ST_RESP;
      ST_RESP: begin
        if (m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= state_q == ST_SCAN;
    end
  end

  // Hold the request and the index of the slot now in the read register
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= rd_addr;
    if (in_acc) begin
      req_op_q     <= s_axis_tuser;
      req_addr_q   <= s_axis_tdata[31:0];
      req_len_q    <= s_axis_tdata[63:32];
      req_end_q    <= {1'b0, s_axis_tdata[31:0]} + {1'b0, s_axis_tdata[63:32]};
      req_fixed_q  <= s_axis_tdata[64];
      req_shared_q <= s_axis_tdata[65];
      req_anon_q   <= s_axis_tdata[66];
      req_fd_q     <= s_axis_tdata[70:67];
      req_idx_q    <= s_axis_tdata[74:71];
    end
  end

  mrt_slot_mem #(
    .DEPTH (TABLE_SLOTS),
    .AW    (IW)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (free_idx_q),
    .wdata_i (wr_entry),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Shared compare unit: interval intersection and start match on one slot
  assign slot_live_w = valid_q[cmp_idx_q];
  assign slot_end_w  = {1'b0, rd_data.start} + {2'b0, rd_data.len};
  assign overlap_w   = slot_live_w && ({1'b0, req_addr_q} < slot_end_w)
                       && ({1'b0, rd_data.start} < req_end_q);
  assign match_w     = slot_live_w && (rd_data.start == req_addr_q);

  // Accumulate scan results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q         <= 1'b0;
      free_found_q  <= 1'b0;
      match_found_q <= 1'b0;
      free_idx_q    <= '0;
      match_idx_q   <= '0;
    end else if (in_acc) begin
      hit_q         <= 1'b0;
      free_found_q  <= 1'b0;
      match_found_q <= 1'b0;
    end else if (cmp_vld_q) begin
      if (overlap_w) begin
        hit_q <= 1'b1;
      end
      if (!slot_live_w && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= cmp_idx_q;
      end
      if (match_w && !match_found_q) begin
        match_found_q <= 1'b1;
        match_idx_q   <= cmp_idx_q;
      end
    end
  end

  // Map checks that need no table access
  assign pre_ok = req_fixed_q && req_shared_q
                  && (req_addr_q >= WinLow) && (req_addr_q < WinHigh)
                  && ((req_addr_q & PageMask) == 32'd0)
                  && !req_len_q[31] && (req_len_q != 32'd0)
                  && (req_end_q < {1'b0, WinHigh});
  assign map_ok   = pre_ok && !hit_q && free_found_q;
  assign unmap_ok = match_found_q;
  assign idx_ok   = 32'(req_idx_q) < TABLE_SLOTS;

  assign mem_we         = (state_q == ST_COMMIT) && (req_op_q == OP_MAP) && map_ok;
  assign wr_entry.start = req_addr_q;
  assign wr_entry.len   = req_len_q[30:0];
  assign wr_entry.file  = req_anon_q ? 5'd0 : (5'(req_fd_q) + 5'd1);

  // Commit: update valid bits and count, build the result item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      live_cnt_q <= '0;
    end else if (state_q == ST_COMMIT) begin
      case (req_op_q)
        OP_MAP: begin
          if (map_ok) begin
            valid_q[free_idx_q] <= 1'b1;
            live_cnt_q          <= live_cnt_q + 1'b1;
          end
        end
        OP_UNMAP: begin
          if (unmap_ok) begin
            valid_q[match_idx_q] <= 1'b0;
            if (live_cnt_q != '0) begin
              live_cnt_q <= live_cnt_q - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_d = '0;
    case (req_op_q)
      OP_MAP: begin
        if (map_ok) begin
          out_d[32:1]  = req_addr_q;
          out_d[74:70] = 5'(live_cnt_q + 1'b1);
        end else begin
          out_d[0]     = 1'b1;
          out_d[74:70] = 5'(live_cnt_q);
        end
      end
      OP_UNMAP: begin
        out_d[0] = !unmap_ok;
        if (unmap_ok && (live_cnt_q != '0)) begin
          out_d[74:70] = 5'(live_cnt_q - 1'b1);
        end else begin
          out_d[74:70] = 5'(live_cnt_q);
        end
      end
      OP_QUERY: begin
        out_d[0]     = !idx_ok;
        out_d[74:70] = 5'(live_cnt_q);
        if (idx_ok && slot_live_w) begin
          out_d[32:1]  = rd_data.start;
          out_d[63:33] = rd_data.len;
          out_d[68:64] = rd_data.file;
          out_d[69]    = 1'b1;
        end
      end
      default: begin
        out_d[0]     = 1'b1;
        out_d[74:70] = 5'(live_cnt_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_COMMIT) begin
      out_q <= out_d;
    end
  end

endmodule

// File: rtl/mrt_checker.sv
module mrt_checker
  import mrt_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // One item at a time: no new item while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a result is pending");

  // Busy right after an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready again right after an accepted item");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // A live slot is only reported with success
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[69]) |-> !m_axis_tdata[0])
    else $error("live slot reported with failed status");

  // Length and file fields are zero unless a live slot is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[69]) |->
      ((m_axis_tdata[63:33] == 31'd0) && (m_axis_tdata[68:64] == 5'd0)))
    else $error("slot fields set without a live slot");

endmodule

bind mapped_region_table mrt_checker u_mrt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mrt_pkg::*;

  localparam int unsigned TableSlots  = 16;
  localparam int unsigned PageBytes   = 4096;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned RandomItems = 1750;
  // Pages at the bottom of the window that random maps crowd into
  localparam int unsigned LowSpan     = 64;

  // Operation code that the block does not define
  localparam logic [1:0] OpUndef = 2'd3;

  // Request flag bits, in tdata order
  localparam logic [2:0] FlagFixed  = 3'b001;
  localparam logic [2:0] FlagShared = 3'b010;
  localparam logic [2:0] FlagAnon   = 3'b100;
  localparam logic [2:0] MapFlags   = FlagFixed | FlagShared;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [31:0] length;
    logic [2:0]  flags;
    logic [3:0]  fd;
    logic [3:0]  idx;
  } request_t;

  typedef struct packed {
    logic        status;
    logic [31:0] addr;
    logic [30:0] len;
    logic [4:0]  file;
    logic        live;
    logic [4:0]  count;
  } reply_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [OpW-1:0]      s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // Shadow copy of the region table
  bit          tbl_live    [TableSlots];
  bit          tbl_written [TableSlots];
  mrt_entry_t  tbl_entry   [TableSlots];
  int unsigned tbl_count;

  reply_t      reply_q[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;

  mapped_region_table #(
    .TABLE_SLOTS(TableSlots),
    .PAGE_BYTES (PageBytes)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Apply one request to the shadow table and return the reply it should produce
  function automatic reply_t apply_request(request_t rq);
    reply_t      rp;
    logic [32:0] rq_end;
    logic [32:0] slot_end;
    int          free_slot;
    int          i;
    bit          ok;
    rp        = '0;
    rp.status = 1'b1;
    case (rq.op)
      OP_MAP: begin
        rq_end = {1'b0, rq.addr} + {1'b0, rq.length};
        ok = rq.flags[0] && rq.flags[1] && rq.addr >= WinLow && rq.addr < WinHigh &&
             (rq.addr % PageBytes) == 0 && !rq.length[31] && rq.length != '0 &&
             rq_end < {1'b0, WinHigh};
        free_slot = -1;
        for (i = 0; i < TableSlots; i++) begin
          if (!tbl_live[i]) begin
            if (free_slot < 0) free_slot = i;
          end else begin
            // full interval intersection against every live region
            slot_end = {1'b0, tbl_entry[i].start} + {2'b0, tbl_entry[i].len};
            if ({1'b0, rq.addr} < slot_end && {1'b0, tbl_entry[i].start} < rq_end) ok = 1'b0;
          end
        end
        if (ok && free_slot >= 0) begin
          tbl_live[free_slot]       = 1'b1;
          tbl_written[free_slot]    = 1'b1;
          tbl_entry[free_slot].start = rq.addr;
          tbl_entry[free_slot].len   = rq.length[30:0];
          tbl_entry[free_slot].file  = rq.flags[2] ? 5'd0 : {1'b0, rq.fd} + 5'd1;
          tbl_count++;
          rp.status = 1'b0;
          rp.addr   = rq.addr;
        end
      end
      OP_UNMAP: begin
        // remove the lowest live slot that starts here
        for (i = 0; i < TableSlots && rp.status; i++) begin
          if (tbl_live[i] && tbl_entry[i].start == rq.addr) begin
            tbl_live[i] = 1'b0;
            tbl_count--;
            rp.status = 1'b0;
          end
        end
      end
      OP_QUERY: begin
        if (rq.idx < TableSlots) begin
          rp.status = 1'b0;
          if (tbl_live[rq.idx]) begin
            rp.live = 1'b1;
            rp.addr = tbl_entry[rq.idx].start;
            rp.len  = tbl_entry[rq.idx].len;
            rp.file = tbl_entry[rq.idx].file;
          end
        end
      end
      default: ;
    endcase
    rp.count = tbl_count[4:0];
    return rp;
  endfunction

  function automatic request_t make_req(logic [1:0] op, logic [31:0] addr,
                                        logic [31:0] length, logic [2:0] flags,
                                        logic [3:0] fd, logic [3:0] idx);
    request_t rq;
    rq.op     = op;
    rq.addr   = addr;
    rq.length = length;
    rq.flags  = flags;
    rq.fd     = fd;
    rq.idx    = idx;
    return rq;
  endfunction

  // Offer one item, optionally after a gap, and record its reply once taken
  task automatic send_item(request_t rq);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < snd_idle_pct) ? $urandom_range(1, 24) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq.op;
    s_axis_tdata  <= {5'b0, rq.idx, rq.fd, rq.flags, rq.length, rq.addr};
    do @(posedge clk_i); while (!s_axis_tready);
    reply_q.push_back(apply_request(rq));
  endtask

  // Drop valid and hold until every pending reply is in
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (reply_q.size() != 0);
  endtask

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
      fail_count++;
    end
  endfunction

  // Every field rule of a map, each extreme of the fields
  task automatic test_map_checks();
    send_item(make_req(OP_MAP, WinLow, 32'd1, MapFlags, 4'hF, 4'h0));
    send_item(make_req(OP_MAP, 32'h6001_0000, 32'h1000, FlagFixed, 4'h3, 4'h0));
    send_item(make_req(OP_MAP, 32'h6001_0000, 32'h1000, FlagShared, 4'h3, 4'h0));
    send_item(make_req(OP_MAP, 32'h6001_0000, 32'h1000, FlagAnon, 4'h3, 4'h0));
    send_item(make_req(OP_MAP, 32'h6001_0800, 32'h1000, MapFlags, 4'h3, 4'h0));
    send_item(make_req(OP_MAP, WinLow - PageBytes, 32'h1000, MapFlags, 4'h3, 4'h0));
    send_item(make_req(OP_MAP, WinHigh, 32'h1000, MapFlags, 4'h3, 4'h0));
    send_item(make_req(OP_MAP, 32'hFFFF_F000, 32'd1, MapFlags, 4'h3, 4'hF));
    send_item(make_req(OP_MAP, 32'h6001_0000, 32'd0, MapFlags, 4'h3, 4'h0));
    send_item(make_req(OP_MAP, 32'h6001_0000, 32'h8000_0000, MapFlags, 4'h3, 4'h0));
    send_item(make_req(OP_MAP, 32'h6001_0000, 32'hFFFF_FFFF, MapFlags, 4'h3, 4'h0));
    send_item(make_req(OP_MAP, WinLow, 32'h7FFF_FFFF, MapFlags, 4'h3, 4'h0));
    // end exactly at the top of the window fails, one byte less fits
    send_item(make_req(OP_MAP, WinHigh - PageBytes, PageBytes, MapFlags, 4'h3, 4'h0));
    send_item(make_req(OP_MAP, WinHigh - PageBytes, PageBytes - 1, MapFlags | FlagAnon,
                       4'h5, 4'h0));
    send_item(make_req(OP_MAP, 32'h6001_0000, 32'h2000, MapFlags, 4'h0, 4'h0));
    drain_replies();
  endtask

  // Overlap from below, from inside and at the same start, touching neighbors allowed
  task automatic test_overlap();
    send_item(make_req(OP_MAP, WinLow, PageBytes, MapFlags, 4'h1, 4'h0));
    send_item(make_req(OP_MAP, 32'h6000_F000, 32'h1001, MapFlags, 4'h1, 4'h0));
    send_item(make_req(OP_MAP, 32'h6000_F000, 32'h1000, MapFlags, 4'h1, 4'h0));
    send_item(make_req(OP_MAP, 32'h6001_1000, 32'd1, MapFlags, 4'h1, 4'h0));
    send_item(make_req(OP_MAP, 32'h6001_2000, 32'h1000, MapFlags, 4'h1, 4'h0));
    drain_replies();
  endtask

  // Unmap hit and miss, queries of live and freed slots, the undefined code
  task automatic test_unmap_query();
    send_item(make_req(OP_QUERY, '0, '0, '0, 4'h0, 4'd2));
    send_item(make_req(OP_UNMAP, 32'h6001_0000, '0, '0, 4'h0, 4'h0));
    send_item(make_req(OP_UNMAP, 32'h6001_0000, '0, '0, 4'h0, 4'h0));
    send_item(make_req(OP_QUERY, '0, '0, '0, 4'h0, 4'd2));
    send_item(make_req(OP_QUERY, '0, '0, '0, 4'h0, 4'd1));
    send_item(make_req(OpUndef, 32'h6002_0000, 32'h1000, MapFlags, 4'h7, 4'd1));
    // lowest free slot is reused
    send_item(make_req(OP_MAP, 32'h6001_0000, 32'h800, MapFlags, 4'h9, 4'h0));
    send_item(make_req(OP_QUERY, '0, '0, '0, 4'h0, 4'd2));
    drain_replies();
  endtask

  // Mostly well-formed map/unmap/query traffic on a crowded window, some noise
  task automatic test_random_traffic(int unsigned n);
    request_t    rq;
    int unsigned k;
    int unsigned j;
    int unsigned slot;
    int unsigned base;
    int unsigned pick;
    int unsigned map_w;
    logic [31:0] rnd;
    bit          found;
    map_w = 45;
    for (k = 0; k < n; k++) begin
      // shift the balance so the table both fills and empties
      if (k % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       map_w = 20;
          1:       map_w = 45;
          default: map_w = 65;
        endcase
      end
      if (k == n / 2) drain_replies();

      rnd       = $urandom;
      rq.op     = OP_MAP;
      rq.flags  = MapFlags | (rnd[8] ? FlagAnon : 3'b000);
      rq.fd     = rnd[3:0];
      rq.idx    = rnd[7:4];
      if ($urandom_range(0, 7) == 0)
        rq.addr = WinHigh - $urandom_range(1, 16) * PageBytes;
      else
        rq.addr = WinLow + $urandom_range(0, LowSpan - 1) * PageBytes;
      if ($urandom_range(0, 3) == 0)
        rq.length = $urandom_range(1, 4) * PageBytes;
      else
        rq.length = $urandom_range(1, 4 * PageBytes);

      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // break one rule of the request
        case ($urandom_range(0, 7))
          0: rq.op = OpUndef;
          1: rq.flags[1:0] = rnd[10:9] & {~rnd[11], rnd[11]};
          2: rq.addr = $urandom;
          3: rq.addr = rq.addr + $urandom_range(1, PageBytes - 1);
          4: rq.length = $urandom;
          5: rq.length = rnd[12] ? 32'd0 : ($urandom | 32'h8000_0000);
          6: rq.length = WinHigh - rq.addr - {31'd0, rnd[13]};
          default: begin
            rq.op   = OP_UNMAP;
            rq.addr = $urandom;
          end
        endcase
      end else if (pick < 10 + map_w) begin
        // keep the well-formed map
      end else if (pick < 10 + map_w + (90 - map_w) / 2) begin
        rq.op = OP_UNMAP;
        if ($urandom_range(0, 9) != 0) begin
          base  = $urandom_range(0, TableSlots - 1);
          found = 1'b0;
          for (j = 0; j < TableSlots; j++) begin
            slot = (base + j) % TableSlots;
            if (!found && tbl_live[slot]) begin
              rq.addr = tbl_entry[slot].start;
              found   = 1'b1;
            end
          end
        end
      end else begin
        // query only slots that have held a region; fall back to a map
        base  = $urandom_range(0, TableSlots - 1);
        found = 1'b0;
        for (j = 0; j < TableSlots; j++) begin
          slot = (base + j) % TableSlots;
          if (!found && tbl_written[slot]) begin
            rq.op  = OP_QUERY;
            rq.idx = slot[3:0];
            found  = 1'b1;
          end
        end
      end
      send_item(rq);
    end
    drain_replies();
  endtask

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Compare each result with the oldest pending reply
  always @(posedge clk_i) begin
    reply_t got;
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[0];
      got.addr   = m_axis_tdata[32:1];
      got.len    = m_axis_tdata[63:33];
      got.file   = m_axis_tdata[68:64];
      got.live   = m_axis_tdata[69];
      got.count  = m_axis_tdata[74:70];
      if (reply_q.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, got %0h",
                 $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = reply_q.pop_front();
        check_field("status", want.status, got.status);
        check_field("result_addr", want.addr, got.addr);
        check_field("result_length", want.len, got.len);
        check_field("result_file", want.file, got.file);
        check_field("slot_live", want.live, got.live);
        check_field("region_count", want.count, got.count);
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results pending", $time, reply_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    snd_idle_pct = 6;
    rcv_idle_pct = 67;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_map_checks();
    test_overlap();
    test_unmap_query();
    test_random_traffic(RandomItems / 3);

    snd_idle_pct = 67;
    rcv_idle_pct = 6;
    test_random_traffic(RandomItems / 3);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_traffic(RandomItems - 2 * (RandomItems / 3));

    // let any stray result show up
    repeat (2 * TableSlots + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
